// ----- rtl/rcpt_pkg.sv -----
// Shared types, sizes and codes for the residue class propensity table.
`timescale 1ns / 1ps
package rcpt_pkg;

  localparam int NUM_KINDS   = 20;
  localparam int NUM_CLASSES = 7;
  localparam int COUNT_BITS  = 24;

  localparam int RES_W     = 5;
  localparam int CLS_W     = 3;
  localparam int RATIO_W   = 32;
  localparam int FRAC_BITS = 16;

  localparam int NUM_CELLS = NUM_KINDS * NUM_CLASSES;
  localparam int CELL_AW   = $clog2(NUM_CELLS);
  localparam int KIND_AW   = $clog2(NUM_KINDS);
  localparam int CLS_AW    = $clog2(NUM_CLASSES);

  localparam int RES_TOT_W = COUNT_BITS + $clog2(NUM_CLASSES);
  localparam int CLS_TOT_W = COUNT_BITS + $clog2(NUM_KINDS);
  localparam int GRAND_W   = COUNT_BITS + $clog2(NUM_CELLS);

  localparam int MUL_A_W = CLS_TOT_W;
  localparam int MUL_B_W = GRAND_W;
  localparam int NUM_W   = COUNT_BITS + GRAND_W;
  localparam int DEN_W   = RES_TOT_W + CLS_TOT_W;
  localparam int STEP_W  = $clog2(RATIO_W);

  localparam logic [RES_W:0] KINDS_LIM   = (RES_W + 1)'(NUM_KINDS);
  localparam logic [CLS_W:0] CLASSES_LIM = (CLS_W + 1)'(NUM_CLASSES);

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [RES_W-1:0] residue;
    logic [CLS_W-1:0] env_class;
    logic             standard;
  } item_t;

  typedef struct packed {
    logic [RES_W-1:0]   residue_out;
    logic [CLS_W-1:0]   class_out;
    logic [RATIO_W-1:0] ratio;
    logic               defined;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic                  en;
    logic [CELL_AW-1:0]    addr;
    logic [COUNT_BITS-1:0] data;
  } cell_wr_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic [RATIO_W-1:0] quo;
  } div_res_t;

endpackage

// ----- rtl/residue_class_propensity_table.sv -----
// Top level: contingency table sequencer, totals, shared multiplier and divider.
`timescale 1ns / 1ps
// Usage:
//   Present a word on item_i with start_i high; it is taken at the clock edge
//   where start_i is high and busy_o is low. busy_o stays high until the word
//   is finished, and no further word is taken meanwhile.
//   Count words read the cell, then update it and the totals.
//   Clear words and unused op codes leave busy_o low; clear zeroes every count
//   and total at once through per-cell valid bits.
//   Query words read the cell, form count*grand and class*residue totals in
//   one shared multiplier, one product after the other, then run a restoring
//   divider that yields one quotient bit a cycle over its 32 steps. A ratio
//   that saturates skips the steps, and a propensity that is not defined
//   ends the query before the multiplier.
//   A query's result word appears on result_o with done_o high for exactly
//   one cycle, the first cycle with busy_o low; it is not held, the receiver
//   cannot stall it.
//   Count and clear words give no result.
//   Reset empties the table and all totals; no clearing pass is needed.
module residue_class_propensity_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rcpt_pkg::item_t   item_i,
  output logic              busy_o,
  output logic              done_o,
  output rcpt_pkg::result_t result_o
);
  import rcpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_MUL_DEN,
    S_DIV_GO,
    S_DIV_WAIT
  } state_e;

  state_e                 state_q;
  item_t                  item_q;
  logic [RES_TOT_W-1:0]   res_tot_q [NUM_KINDS];
  logic [CLS_TOT_W-1:0]   cls_tot_q [NUM_CLASSES];
  logic [GRAND_W-1:0]     grand_q;
  logic [NUM_W-1:0]       num_q;
  logic [DEN_W-1:0]       den_q;
  logic                   done_q;
  result_t                result_q;

  logic                   accept;
  logic                   clear;
  logic [KIND_AW-1:0]     kidx;
  logic [CLS_AW-1:0]      cidx;
  logic                   in_range;
  logic [CELL_AW-1:0]     cell_addr;
  logic [COUNT_BITS-1:0]  cell_cnt;
  logic                   do_count;
  logic                   defined;
  cell_wr_t               cell_wr;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [MUL_A_W+MUL_B_W-1:0] prod;
  div_res_t               div_res;

  assign accept    = start_i && (state_q == S_IDLE);
  assign clear     = accept && (item_i.op == OP_CLEAR);
  assign kidx      = item_q.residue[KIND_AW-1:0];
  assign cidx      = item_q.env_class[CLS_AW-1:0];
  assign in_range  = ({1'b0, item_q.residue} < KINDS_LIM)
                  && ({1'b0, item_q.env_class} < CLASSES_LIM);
  assign cell_addr = CELL_AW'(kidx) * CELL_AW'(NUM_CLASSES) + CELL_AW'(cidx);

  assign do_count  = (state_q == S_EXEC) && (item_q.op == OP_COUNT) && item_q.standard
                  && in_range && !(&cell_cnt);
  assign defined   = in_range && (cls_tot_q[cidx] != '0) && (res_tot_q[kidx] != '0);

  assign cell_wr = '{en: do_count, addr: cell_addr, data: cell_cnt + COUNT_BITS'(1)};

  rcpt_cell_mem u_cell_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear),
    .wr_i    (cell_wr),
    .raddr_i (cell_addr),
    .rdata_o (cell_cnt)
  );

  always_comb begin
    if (state_q == S_MUL_DEN) begin
      mul_a = MUL_A_W'(cls_tot_q[cidx]);
      mul_b = MUL_B_W'(res_tot_q[kidx]);
    end else begin
      mul_a = MUL_A_W'(cell_cnt);
      mul_b = grand_q;
    end
  end

  assign prod = mul_a * mul_b;

  rcpt_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIV_GO),
    .num_i   (num_q),
    .den_i   (den_q),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (state_q == S_EXEC) begin
      num_q <= NUM_W'(prod);
    end
    if (state_q == S_MUL_DEN) begin
      den_q <= DEN_W'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      result_q  <= '0;
      grand_q   <= '0;
      res_tot_q <= '{default: '0};
      cls_tot_q <= '{default: '0};
    end else begin
      done_q <= 1'b0;
      if (clear) begin
        grand_q   <= '0;
        res_tot_q <= '{default: '0};
        cls_tot_q <= '{default: '0};
      end
      if (do_count) begin
        grand_q         <= grand_q + GRAND_W'(1);
        res_tot_q[kidx] <= res_tot_q[kidx] + RES_TOT_W'(1);
        cls_tot_q[cidx] <= cls_tot_q[cidx] + CLS_TOT_W'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (accept && (item_i.op == OP_COUNT || item_i.op == OP_QUERY)) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (item_q.op == OP_QUERY && !defined) begin
            done_q   <= 1'b1;
            result_q <= '{residue_out: item_q.residue, class_out: item_q.env_class,
                          ratio: '0, defined: 1'b0, saturated: 1'b0};
            state_q  <= S_IDLE;
          end else if (item_q.op == OP_QUERY) begin
            state_q <= S_MUL_DEN;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_MUL_DEN: begin
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_res.done) begin
            done_q   <= 1'b1;
            result_q <= '{residue_out: item_q.residue, class_out: item_q.env_class,
                          ratio: div_res.quo, defined: 1'b1, saturated: div_res.sat};
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- rtl/rcpt_cell_mem.sv -----
// Cell count memory with per-entry valid bits, so one clear zeroes every entry at once.
`timescale 1ns / 1ps
module rcpt_cell_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  rcpt_pkg::cell_wr_t             wr_i,
  input  logic [rcpt_pkg::CELL_AW-1:0]   raddr_i,
  output logic [rcpt_pkg::COUNT_BITS-1:0] rdata_o
);
  import rcpt_pkg::*;

  logic [COUNT_BITS-1:0] mem [NUM_CELLS];
  logic [NUM_CELLS-1:0]  valid_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[raddr_i];
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ----- rtl/rcpt_divider.sv -----
// Restoring divider: one quotient bit per cycle, Q16.16 with saturation.
`timescale 1ns / 1ps
module rcpt_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rcpt_pkg::NUM_W-1:0]  num_i,
  input  logic [rcpt_pkg::DEN_W-1:0]  den_i,
  output rcpt_pkg::div_res_t          res_o
);
  import rcpt_pkg::*;

  localparam int CMP_W = (NUM_W > DEN_W + FRAC_BITS) ? NUM_W : DEN_W + FRAC_BITS;

  logic                 run_q;
  logic                 done_q;
  logic                 sat_q;
  logic [STEP_W-1:0]    step_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DEN_W-1:0]     den_q;
  logic [RATIO_W-1:0]   lo_q;
  logic [RATIO_W-1:0]   quo_q;

  logic                 sat_hit;
  logic [DEN_W:0]       trial;
  logic                 ge;
  logic [DEN_W:0]       diff;

  assign sat_hit = CMP_W'(num_i) >= CMP_W'({den_i, {FRAC_BITS{1'b0}}});
  assign trial   = {rem_q, lo_q[RATIO_W-1]};
  assign ge      = trial >= {1'b0, den_q};
  assign diff    = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      lo_q   <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        den_q  <= den_i;
        step_q <= '0;
        if (sat_hit) begin
          sat_q  <= 1'b1;
          quo_q  <= '1;
          done_q <= 1'b1;
        end else begin
          sat_q <= 1'b0;
          quo_q <= '0;
          rem_q <= DEN_W'(num_i >> FRAC_BITS);
          lo_q  <= {num_i[FRAC_BITS-1:0], {(RATIO_W - FRAC_BITS){1'b0}}};
          run_q <= 1'b1;
        end
      end else if (run_q) begin
        rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_q  <= {quo_q[RATIO_W-2:0], ge};
        lo_q   <= {lo_q[RATIO_W-2:0], 1'b0};
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(RATIO_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o = '{done: done_q, sat: sat_q, quo: quo_q};

endmodule
